FILE: hdl/address_to_line_lookup_core_defines.svh
// ---------------------------------------------------------------------------
// address_to_line_lookup_core_defines.svh
// assertion macros shared by the address to line lookup rtl
// ---------------------------------------------------------------------------
`ifndef ADDRESS_TO_LINE_LOOKUP_CORE_DEFINES_SVH
`define ADDRESS_TO_LINE_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ATLL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("atll assertion failed");
// condition must never be seen outside reset
`define ATLL_NEVER(lbl, clk, rst_n, expr) \
    `ATLL_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define ATLL_ASSERT(lbl, clk, rst_n, prop)
`define ATLL_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: hdl/atll_pkg.sv
// ---------------------------------------------------------------------------
// atll_pkg
// types and codes of the address to line lookup core
// ---------------------------------------------------------------------------
package atll_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_ORDER     = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;

    localparam int ADDR_W   = 64;
    localparam int LINE_W   = 32;
    localparam int FIDX_W   = 10;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] address;
        logic [LINE_W-1:0] line_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [LINE_W-1:0] found_line;
        logic [ADDR_W-1:0] found_address;
        logic [FIDX_W-1:0] found_index;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
    } t_window;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LINE_W-1:0] line;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_KEY,
        S_WALK,
        S_RESULT
    } t_state;

endpackage

FILE: hdl/atll_ram.sv
// ---------------------------------------------------------------------------
// atll_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module atll_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

FILE: hdl/atll_engine.sv
// ---------------------------------------------------------------------------
// atll_engine
// table memory, append logic and binary search sequencer
// ---------------------------------------------------------------------------
`include "address_to_line_lookup_core_defines.svh"

module atll_engine #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  atll_pkg::t_in_item i_in_data,
    input  atll_pkg::t_window  i_window,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output atll_pkg::t_out_item o_res
);
    import atll_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [ADDR_W-1:0] r_last_addr, n_last_addr;
    logic [ADDR_W-1:0] r_query, n_query;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_key, n_key;
    logic [IW-1:0]   r_best, n_best;
    logic [LINE_W-1:0] r_bline, n_bline;
    logic [ADDR_W-1:0] r_baddr, n_baddr;
    t_out_item       r_res, n_res;

    logic            ram_we;
    logic            ram_re;
    logic [IW-1:0]   ram_raddr;
    t_entry          ram_wdata;
    t_entry          ram_rdata;

    logic            in_acc;
    logic            in_window;
    logic            is_full;
    logic            out_of_order;
    logic            le;
    logic [CW-1:0]   s_lo, s_hi;
    logic [CW:0]     s_sum;
    logic [IW-1:0]   s_mid;
    logic            s_more;
    logic [IW-1:0]   s_last;
    logic            match;
    logic            take;
    logic [IW-1:0]   w_best;
    logic [LINE_W-1:0] w_bline;
    logic [ADDR_W-1:0] w_baddr;
    logic [IW-1:0]   ptr_dec;
    logic            ptr_zero;

    atll_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;
    assign in_acc      = i_in_valid && o_in_ready;

    assign in_window    = (i_in_data.address >= i_window.low) &&
                          (i_in_data.address <= i_window.high);
    assign is_full      = (r_count >= CW'(TABLE_DEPTH));
    assign out_of_order = (r_count != '0) && (i_in_data.address < r_last_addr);
    assign ram_wdata    = '{address: i_in_data.address, line: i_in_data.line_number};

    // one binary search step on the entry read at r_ptr
    assign le     = (ram_rdata.address <= r_query);
    assign s_lo   = le ? (CW'(r_ptr) + CW'(1)) : r_lo;
    assign s_hi   = le ? r_hi : CW'(r_ptr);
    assign s_sum  = {1'b0, s_lo} + {1'b0, s_hi};
    assign s_mid  = IW'(s_sum >> 1);
    assign s_more = (s_lo < s_hi);
    assign s_last = IW'(s_lo - CW'(1));

    // backward walk over entries with the key address, lowest index wins ties
    assign match    = (ram_rdata.address == r_key);
    assign take     = match && (ram_rdata.line >= r_bline);
    assign w_best   = take ? r_ptr : r_best;
    assign w_bline  = take ? ram_rdata.line : r_bline;
    assign w_baddr  = take ? ram_rdata.address : r_baddr;
    assign ptr_dec  = r_ptr - IW'(1);
    assign ptr_zero = (r_ptr == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_QUERY && in_window && r_count != '0) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SEARCH: begin
                if (s_more) begin
                    n_state = S_SEARCH;
                end else if (s_lo == '0) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                n_state = ptr_zero ? S_RESULT : S_WALK;
            end
            S_WALK: begin
                if (!match || ptr_zero) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_last_addr = r_last_addr;
        n_query     = r_query;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_ptr       = r_ptr;
        n_key       = r_key;
        n_best      = r_best;
        n_bline     = r_bline;
        n_baddr     = r_baddr;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '{status: ST_DONE, default: '0};
                    unique case (i_in_data.cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_APPEND: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else if (out_of_order) begin
                                n_res.status = ST_ORDER;
                            end else begin
                                ram_we      = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_last_addr = i_in_data.address;
                            end
                        end
                        CMD_QUERY: begin
                            if (in_window && r_count != '0) begin
                                n_query   = i_in_data.address;
                                n_lo      = '0;
                                n_hi      = r_count;
                                n_ptr     = IW'(r_count >> 1);
                                ram_re    = 1'b1;
                                ram_raddr = IW'(r_count >> 1);
                            end else begin
                                n_res.status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_res.status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (s_more) begin
                    n_ptr     = s_mid;
                    ram_re    = 1'b1;
                    ram_raddr = s_mid;
                end else if (s_lo == '0) begin
                    n_res = '{status: ST_NOT_FOUND, default: '0};
                end else begin
                    n_ptr     = s_last;
                    ram_re    = 1'b1;
                    ram_raddr = s_last;
                end
            end
            S_KEY: begin
                n_key   = ram_rdata.address;
                n_best  = r_ptr;
                n_bline = ram_rdata.line;
                n_baddr = ram_rdata.address;
                if (ptr_zero) begin
                    n_res.status        = ST_FOUND;
                    n_res.found_line    = ram_rdata.line;
                    n_res.found_address = ram_rdata.address;
                    n_res.found_index   = FIDX_W'(r_ptr);
                end else begin
                    n_ptr     = ptr_dec;
                    ram_re    = 1'b1;
                    ram_raddr = ptr_dec;
                end
            end
            S_WALK: begin
                n_best  = w_best;
                n_bline = w_bline;
                n_baddr = w_baddr;
                if (!match || ptr_zero) begin
                    n_res.status        = ST_FOUND;
                    n_res.found_line    = w_bline;
                    n_res.found_address = w_baddr;
                    n_res.found_index   = FIDX_W'(w_best);
                end else begin
                    n_ptr     = ptr_dec;
                    ram_re    = 1'b1;
                    ram_raddr = ptr_dec;
                end
            end
            S_RESULT: begin
                n_res = r_res;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_addr <= n_last_addr;
        r_query     <= n_query;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_ptr       <= n_ptr;
        r_key       <= n_key;
        r_best      <= n_best;
        r_bline     <= n_bline;
        r_baddr     <= n_baddr;
        r_res       <= n_res;
    end

    `ATLL_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(TABLE_DEPTH))
    `ATLL_ASSERT(a_search_span, i_clk, i_rst_n, (r_state == S_SEARCH) |-> ((r_lo < r_hi) && (CW'(r_ptr) < r_hi)))
    `ATLL_ASSERT(a_walk_in_table, i_clk, i_rst_n, (r_state == S_KEY || r_state == S_WALK) |-> (CW'(r_ptr) < r_count))
    `ATLL_ASSERT(a_append_grows, i_clk, i_rst_n, ram_we |=> (r_count == $past(r_count) + CW'(1)))
    `ATLL_NEVER(a_no_rw_overlap, i_clk, i_rst_n, ram_we && ram_re)

endmodule

FILE: hdl/address_to_line_lookup_core.sv
// ---------------------------------------------------------------------------
// address_to_line_lookup_core
// code address to source line lookup over an ordered line table
// ---------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_data): one transaction per
//   command: clear the table, append an (address, line) entry, or query.
//   output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   result transaction per command, in command order.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 sets the window low bound, index 1 the high bound; always ready.
// sequence
//   clear, append, or a query outside the window or on an empty table:
//   straight to the result state; other queries run s search steps and end
//   there when no entry lies at or below the address, else read the key
//   entry and walk w entries, with s = binary search steps (about log2 of
//   the entry count plus one) and w = entries read below the match, up to
//   the first other address. the table ram gives one read per cycle, and
//   each search and walk step reads it once; a new command is taken once
//   the previous result has moved to the output register.
// reset
//   table emptied (count zero), window set to the full address space.
// stall
//   a result waits in the output register while i_out_ready is low; one more
//   command is processed meanwhile and then held until the register drains.
// ---------------------------------------------------------------------------
`include "address_to_line_lookup_core_defines.svh"

module address_to_line_lookup_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  atll_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output atll_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [atll_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atll_pkg::ADDR_W-1:0]    i_cfg_data
);
    import atll_pkg::*;

    // configuration window
    t_window   r_window, n_window;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data, n_out_data;

    // engine result transaction
    logic      res_valid;
    logic      res_ready;
    t_out_item res;

    logic      cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // writes to unknown indexes are dropped
    always_comb begin
        n_window = r_window;
        if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:  n_window.low  = i_cfg_data;
                CFG_RANGE_HIGH: n_window.high = i_cfg_data;
                default:        n_window      = r_window;
            endcase
        end
    end

    atll_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_window    (r_window),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output slot takes a result when empty or draining this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out_data  = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window.low  <= '0;
            r_window.high <= '1;
            r_out_valid   <= 1'b0;
        end else begin
            r_window      <= n_window;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ATLL_ASSERT(a_res_lands, i_clk, i_rst_n,
        (res_valid && res_ready) |=> (o_out_valid && (o_out_data == $past(res))))

endmodule

FILE: test/address_to_line_lookup_checker.sv
// ---------------------------------------------------------------------------
// address_to_line_lookup_checker
// watches the command, result and register channels of the lookup core,
// keeps its own copy of the line table and window, and compares every
// result transaction field by field with the one it worked out
// ---------------------------------------------------------------------------
module address_to_line_lookup_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  atll_pkg::t_in_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  atll_pkg::t_out_item           i_out_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [atll_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [atll_pkg::ADDR_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_found
);
    timeunit 1ns;
    timeprecision 1ps;
    import atll_pkg::*;

    logic [ADDR_W-1:0] entry_addr [TABLE_DEPTH];
    logic [LINE_W-1:0] entry_line [TABLE_DEPTH];
    int                entry_count;
    logic [ADDR_W-1:0] win_low;
    logic [ADDR_W-1:0] win_high;
    t_out_item         owed_results [$];
    t_out_item         want;

    // updates the table copy and returns the result the command owes
    function automatic t_out_item apply_command(t_in_item item);
        t_out_item res;
        int        hit;
        int        pick;
        int        k;
        res = '0;
        res.status = ST_DONE;
        case (item.cmd)
            CMD_CLEAR: begin
                entry_count = 0;
            end
            CMD_APPEND: begin
                if (entry_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else if (entry_count > 0 &&
                             item.address < entry_addr[entry_count-1]) begin
                    res.status = ST_ORDER;
                end else begin
                    entry_addr[entry_count] = item.address;
                    entry_line[entry_count] = item.line_number;
                    entry_count++;
                end
            end
            CMD_QUERY: begin
                res.status = ST_NOT_FOUND;
                hit = entry_count - 1;
                if (item.address < win_low || item.address > win_high)
                    hit = -1;
                // last entry at or below the address
                while (hit >= 0 && entry_addr[hit] > item.address)
                    hit--;
                if (hit >= 0) begin
                    // walk down the equal-address group, lowest index wins ties
                    pick = hit;
                    k = hit - 1;
                    while (k >= 0 && entry_addr[k] == entry_addr[hit]) begin
                        if (entry_line[k] >= entry_line[pick])
                            pick = k;
                        k--;
                    end
                    res.status        = ST_FOUND;
                    res.found_line    = entry_line[pick];
                    res.found_address = entry_addr[pick];
                    res.found_index   = FIDX_W'(pick);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(string name, logic [ADDR_W-1:0] want_v,
                               logic [ADDR_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = 0;
            win_low     = '0;
            win_high    = '1;
            owed_results.delete();
            o_pending   = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANGE_LOW:  win_low  = i_cfg_data;
                    CFG_RANGE_HIGH: win_high = i_cfg_data;
                    default: ;
                endcase
            end
            // results leave before a same-cycle command adds a new one
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with nothing outstanding: %0h",
                           i_out_data);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", ADDR_W'(want.status),
                                ADDR_W'(i_out_data.status));
                    check_field("found_line", ADDR_W'(want.found_line),
                                ADDR_W'(i_out_data.found_line));
                    check_field("found_address", want.found_address,
                                i_out_data.found_address);
                    check_field("found_index", ADDR_W'(want.found_index),
                                ADDR_W'(i_out_data.found_index));
                    o_checked++;
                    if (want.status == ST_FOUND)
                        o_found++;
                end
            end
            if (i_in_valid && i_in_ready)
                owed_results.push_back(apply_command(i_in_data));
            o_pending = owed_results.size();
        end
    end

endmodule

FILE: test/tb_address_to_line_lookup_core.sv
// ---------------------------------------------------------------------------
// tb_address_to_line_lookup_core
// drives clear, append and query commands into the lookup core, with a
// directed opening followed by randomly built line tables, one filled to
// capacity, each searched under a series of address windows; results are
// checked by the checker module, this module makes stimulus and verdict
// ---------------------------------------------------------------------------
module tb_address_to_line_lookup_core;
    timeunit 1ns;
    timeprecision 1ps;
    import atll_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int RANDOM_ITEMS = 1350;
    localparam int QUIET_LIMIT  = 20000;

    localparam logic [1:0]        CMD_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_MAX   = '1;
    localparam logic [LINE_W-1:0] LINE_MAX   = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE_LOW;
    logic [ADDR_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int found;

    // stimulus-side view of the table, only used to aim appends and queries
    logic [ADDR_W-1:0] shadow_addr [DEPTH];
    int                shadow_count = 0;
    logic [LINE_W-1:0] prev_line    = '0;

    bit burst      = 1'b0;   // no gaps and no output stalls while set
    int stall_left = 0;
    int quiet      = 0;

    int items_sent   = 0;
    int appends_sent = 0;
    int windows_set  = 0;
    int deepest      = 0;

    address_to_line_lookup_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    address_to_line_lookup_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_lookup_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_found      (found)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(negedge clk) begin
        if (burst) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 3);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // gap before a command transaction
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // lines: extremes, repeats of the previous line to make ties, random
    function automatic logic [LINE_W-1:0] pick_line();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 14)
            return LINE_MAX;
        if (r < 35)
            return prev_line;
        return $urandom;
    endfunction

    // next ascending address; a zero step repeats the address
    function automatic logic [ADDR_W-1:0] next_entry_addr(bit allow_wide);
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] sum;
        int                r;
        r = $urandom_range(0, 99);
        if (shadow_count == 0) begin
            if (r < 10)
                return '0;
            if (r < 50)
                return rand_addr() >> $urandom_range(1, 63);
            return rand_addr();
        end
        last = shadow_addr[shadow_count-1];
        if (r < 25)
            step = '0;
        else if (r < 75)
            step = ADDR_W'($urandom_range(1, 16));
        else if (r < 93 || !allow_wide)
            step = ADDR_W'($urandom);
        else
            step = rand_addr() >> $urandom_range(1, 63);
        sum = last + step;
        // saturate instead of wrapping below the last entry
        return (sum < last) ? ADDR_MAX : sum;
    endfunction

    // query addresses aimed at entries, their neighbors and the table edges
    function automatic logic [ADDR_W-1:0] query_addr();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (shadow_count == 0 || r >= 80) begin
            k = $urandom_range(0, 9);
            if (k == 0)
                return '0;
            if (k == 1)
                return ADDR_MAX;
            return rand_addr();
        end
        k = $urandom_range(0, shadow_count - 1);
        if (r < 40)
            return shadow_addr[k];
        if (r < 55)
            return shadow_addr[k] + ADDR_W'(1);
        if (r < 70)
            return shadow_addr[k] - ADDR_W'(1);
        if (r < 75)
            return shadow_addr[0] - ADDR_W'($urandom_range(1, 4));
        return shadow_addr[shadow_count-1] + ADDR_W'($urandom_range(1, 4));
    endfunction

    // one command transaction; entered and left at a falling edge, valid
    // stays high so a following call can present the next command at once
    task automatic send(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                        logic [LINE_W-1:0] line);
        t_in_item it;
        int       gap;
        it.cmd         = cmd;
        it.address     = addr;
        it.line_number = line;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (cmd == CMD_CLEAR) begin
            shadow_count = 0;
        end else if (cmd == CMD_APPEND) begin
            appends_sent++;
            prev_line = line;
            if (shadow_count < DEPTH &&
                (shadow_count == 0 || addr >= shadow_addr[shadow_count-1])) begin
                shadow_addr[shadow_count] = addr;
                shadow_count++;
            end
        end
        if (shadow_count > deepest)
            deepest = shadow_count;
    endtask

    // unused command, appends below the last entry, stray appends and queries
    task automatic send_noise();
        int                r;
        logic [ADDR_W-1:0] last;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send(CMD_UNUSED, rand_addr(), $urandom);
        end else if (r < 80 && shadow_count > 0 &&
                     shadow_addr[shadow_count-1] != '0) begin
            last = shadow_addr[shadow_count-1];
            send(CMD_APPEND,
                 $urandom_range(0, 1) ? last - ADDR_W'(1) : rand_addr() % last,
                 pick_line());
        end else if (r < 95) begin
            send(CMD_APPEND, rand_addr(), $urandom);
        end else begin
            send(CMD_QUERY, rand_addr(), $urandom);
        end
    endtask

    // drop valid and let every owed result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // window registers change only with the core idle, in random order
    task automatic set_window(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        wait_idle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_RANGE_LOW, lo);
            write_reg(CFG_RANGE_HIGH, hi);
        end else begin
            write_reg(CFG_RANGE_HIGH, hi);
            write_reg(CFG_RANGE_LOW, lo);
        end
        cfg_valid <= 1'b0;
        windows_set++;
    endtask

    // new window, then a batch of mostly queries against the current table
    task automatic query_round();
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        int                i;
        int                j;
        int                r;
        a = rand_addr();
        b = rand_addr();
        if (a == b)
            b = ~a;
        i = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
        j = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
        // cycle through window shapes so every extreme shows up
        case (windows_set % 9)
            0: begin lo = '0; hi = ADDR_MAX; end
            1: begin
                // inverted window, low above high
                if ($urandom_range(0, 1)) begin
                    lo = ADDR_MAX;
                    hi = '0;
                end else begin
                    lo = (a > b) ? a : b;
                    hi = (a > b) ? b : a;
                end
            end
            2: begin lo = '0; hi = '0; end
            3: begin lo = ADDR_MAX; hi = ADDR_MAX; end
            4: begin
                lo = (shadow_count > 0) ? shadow_addr[i] : a;
                hi = lo;
            end
            5: begin
                lo = (shadow_count > 0) ? shadow_addr[(i < j) ? i : j] : '0;
                hi = (shadow_count > 0) ? shadow_addr[(i < j) ? j : i] : ADDR_MAX;
            end
            6: begin
                lo = (shadow_count > 0) ? shadow_addr[i] + ADDR_W'(1) : a;
                hi = ADDR_MAX;
            end
            7: begin
                lo = '0;
                hi = (shadow_count > 0) ? shadow_addr[i] - ADDR_W'(1) : b;
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
        set_window(lo, hi);
        burst <= ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(8, 24)) begin
            r = $urandom_range(0, 99);
            if (r < 78)
                send(CMD_QUERY, query_addr(), $urandom);
            else if (r < 88)
                send(CMD_APPEND, next_entry_addr(1'b1), pick_line());
            else if (r < 99)
                send_noise();
            else
                send(CMD_CLEAR, rand_addr(), $urandom);
        end
    endtask

    // small table with duplicates and the odd rejected append in between
    task automatic build_table();
        int n;
        send(CMD_CLEAR, rand_addr(), $urandom);
        burst <= ($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
        repeat (n) begin
            if ($urandom_range(0, 99) < 8)
                send_noise();
            send(CMD_APPEND, next_entry_addr(1'b1), pick_line());
        end
    endtask

    // fill the table to capacity, then appends in and out of order are refused
    task automatic fill_table();
        send(CMD_CLEAR, rand_addr(), $urandom);
        burst <= 1'b0;
        while (shadow_count < DEPTH) begin
            if ($urandom_range(0, 99) == 0)
                send_noise();
            send(CMD_APPEND, next_entry_addr(1'b0), pick_line());
        end
        send(CMD_APPEND, ADDR_MAX, pick_line());
        send(CMD_APPEND, '0, pick_line());
        repeat (4)
            send(CMD_APPEND, rand_addr(), $urandom);
    endtask

    initial begin
        int session;
        int directed;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening, reset window covers every address
        send(CMD_QUERY, '0, LINE_MAX);              // empty table
        send(CMD_UNUSED, ADDR_MAX, LINE_MAX);       // unused command code
        send(CMD_APPEND, 64'd100, 32'd5);
        send(CMD_APPEND, 64'd100, 32'd9);           // equal address accepted
        send(CMD_APPEND, 64'd100, 32'd9);           // tie, lower index wins
        send(CMD_APPEND, 64'd50, 32'd1);            // below last, refused
        send(CMD_APPEND, 64'd200, '0);
        send(CMD_APPEND, ADDR_MAX, LINE_MAX);
        send(CMD_QUERY, 64'd99, '0);                // below first entry
        send(CMD_QUERY, 64'd100, '0);
        send(CMD_QUERY, 64'd150, '0);
        send(CMD_QUERY, 64'd200, '0);
        send(CMD_QUERY, ADDR_MAX, '0);
        set_window(64'd101, 64'd199);
        send(CMD_QUERY, 64'd100, '0);               // under the window
        send(CMD_QUERY, 64'd150, '0);
        send(CMD_QUERY, 64'd200, '0);               // over the window
        set_window(64'd200, 64'd100);               // inverted window
        send(CMD_QUERY, 64'd150, '0);
        set_window('0, ADDR_MAX);
        send(CMD_CLEAR, '0, '0);
        send(CMD_QUERY, 64'd100, '0);               // cleared table
        send(CMD_APPEND, '0, '0);
        send(CMD_QUERY, '0, LINE_MAX);
        directed = items_sent;

        // random sessions: each builds a table and searches it in three windows
        session = 0;
        while (items_sent < directed + RANDOM_ITEMS) begin
            burst <= 1'b0;
            if (session == 1)
                fill_table();
            else
                build_table();
            repeat (3)
                query_round();
            session++;
        end

        burst <= 1'b0;
        wait_idle();
        repeat (20) @(negedge clk);
        $display("ran %0d commands (%0d appends, tables up to %0d entries) under %0d windows",
                 items_sent, appends_sent, deepest, windows_set);
        $display("%0d result transactions checked, %0d lookups returned a line",
                 checked, found);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/atll_pkg.sv
hdl/atll_ram.sv
hdl/atll_engine.sv
hdl/address_to_line_lookup_core.sv
test/address_to_line_lookup_checker.sv
test/tb_address_to_line_lookup_core.sv
